>>> rtl/all_pkg.sv
// Shared types and constants of the array linked list engine.
package all_pkg;

  localparam int MaxNodes  = 64;
  localparam int SlotBits  = 7;
  localparam int IdxBits   = 6;
  localparam int ValueBits = 32;
  localparam int TagBits   = 8;

  localparam logic [SlotBits-1:0] NoneSlot = SlotBits'(MaxNodes);

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_INS_BEFORE = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_DELETE     = 3'd3,
    OP_FIND       = 3'd4,
    OP_READ       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADSLOT  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RDFREE, S_RDIDX, S_LINK, S_FIX, S_REREAD,
    S_WALK, S_CHECK, S_DEL, S_DELFIX, S_OK, S_ERR, S_WAIT
  } ctrl_state_e;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,      // capture the input beat
    CMD_RD_CUR,     // read node at cursor
    CMD_RD_IDX,     // read node at index
    CMD_RD_FREE,    // read forward link of free head
    CMD_APPEND,     // link new node at tail
    CMD_INS_B,      // link new node before index
    CMD_INS_A,      // link new node after index
    CMD_INS_FIX,    // fix neighbor of inserted node
    CMD_DEL,        // unlink node at cursor, first half
    CMD_DEL_FIX,    // unlink second half; node freed on result
    CMD_STEP,       // advance cursor
    CMD_RESULT      // emit result
  } cmd_e;

  typedef struct packed {
    cmd_e    cmd;
    status_e status;
    logic    use_node;
  } all_ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       idx_ok;
    logic       free_ok;
    logic       cur_none;
    logic       match;
  } all_sts_t;

endpackage

>>> rtl/all_datapath.sv
// Node memories, list registers and result register of the list engine.
module all_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [2:0]                      op_i,
  input  logic [all_pkg::ValueBits-1:0]   item_value_i,
  input  logic [all_pkg::TagBits-1:0]     type_tag_i,
  input  logic [all_pkg::IdxBits-1:0]     slot_i,
  input  all_pkg::all_ctl_t               ctl_i,
  output all_pkg::all_sts_t               sts_o,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [all_pkg::SlotBits-1:0]    result_slot_o,
  output logic [all_pkg::ValueBits-1:0]   result_value_o,
  output logic [all_pkg::TagBits-1:0]     result_tag_o,
  output logic [all_pkg::SlotBits-1:0]    next_slot_o,
  output logic [all_pkg::SlotBits-1:0]    prev_slot_o,
  output logic [all_pkg::SlotBits-1:0]    count_o,
  output logic [all_pkg::SlotBits-1:0]    head_slot_o,
  output logic [all_pkg::SlotBits-1:0]    tail_slot_o
);
  localparam int SB = all_pkg::SlotBits;
  localparam int IB = all_pkg::IdxBits;
  localparam logic [SB-1:0] NONE = all_pkg::NoneSlot;

  // Node stores; forward links reset to a free chain via valid bits.
  logic [all_pkg::ValueBits-1:0] val_mem [all_pkg::MaxNodes];
  logic [all_pkg::TagBits-1:0]   tag_mem [all_pkg::MaxNodes];
  logic [SB-1:0]                 fwd_mem [all_pkg::MaxNodes];
  logic [SB-1:0]                 bwd_mem [all_pkg::MaxNodes];
  logic [all_pkg::MaxNodes-1:0]  fwd_vld_q, in_use_q;

  logic [2:0]                    op_q;
  logic [all_pkg::ValueBits-1:0] val_q;
  logic [all_pkg::TagBits-1:0]   tag_q;
  logic [IB-1:0]                 idx_q;
  logic [SB-1:0] head_q, tail_q, free_q, cnt_q, cur_q, new_q, nbr_q;
  // Registered read of the addressed node: cursor, index or free head.
  logic [all_pkg::ValueBits-1:0] rd_val_q;
  logic [all_pkg::TagBits-1:0]   rd_tag_q;
  logic [SB-1:0]                 rd_fwd_q, rd_bwd_q, free_nxt_q;

  // Registered result outputs.
  logic                          done_q;
  logic [1:0]                    st_q;
  logic [SB-1:0] rs_q, rn_q, rp_q;
  logic [all_pkg::ValueBits-1:0] rv_q;
  logic [all_pkg::TagBits-1:0]   rt_q;

  // Read address selection.
  logic [IB-1:0] ra;
  always_comb begin
    case (ctl_i.cmd)
      all_pkg::CMD_RD_IDX:  ra = idx_q;
      all_pkg::CMD_RD_FREE: ra = free_q[IB-1:0];
      default:              ra = cur_q[IB-1:0];
    endcase
  end

  // Report status to the controller.
  always_comb begin
    sts_o.op       = op_q;
    sts_o.idx_ok   = in_use_q[idx_q];
    sts_o.free_ok  = (free_q != NONE);
    sts_o.cur_none = (cur_q == NONE);
    sts_o.match    = (rd_val_q == val_q);
  end

  // Memory port: one write, registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == all_pkg::CMD_RD_CUR || ctl_i.cmd == all_pkg::CMD_RD_IDX ||
        ctl_i.cmd == all_pkg::CMD_RD_FREE) begin
      rd_val_q <= val_mem[ra];
      rd_tag_q <= tag_mem[ra];
      rd_fwd_q <= fwd_vld_q[ra] ? fwd_mem[ra] : SB'({1'b0, ra} + 1'b1);
      rd_bwd_q <= bwd_mem[ra];
    end
    if (ctl_i.cmd == all_pkg::CMD_RD_FREE)
      free_nxt_q <= fwd_vld_q[ra] ? fwd_mem[ra] : SB'({1'b0, ra} + 1'b1);
    case (ctl_i.cmd)
      all_pkg::CMD_APPEND: begin
        val_mem[free_q[IB-1:0]] <= val_q;
        tag_mem[free_q[IB-1:0]] <= tag_q;
        fwd_mem[free_q[IB-1:0]] <= NONE;
        bwd_mem[free_q[IB-1:0]] <= tail_q;
      end
      all_pkg::CMD_INS_B: begin
        val_mem[free_q[IB-1:0]] <= val_q;
        tag_mem[free_q[IB-1:0]] <= tag_q;
        fwd_mem[free_q[IB-1:0]] <= {1'b0, idx_q};
        bwd_mem[free_q[IB-1:0]] <= rd_bwd_q;
      end
      all_pkg::CMD_INS_A: begin
        val_mem[free_q[IB-1:0]] <= val_q;
        tag_mem[free_q[IB-1:0]] <= tag_q;
        fwd_mem[free_q[IB-1:0]] <= rd_fwd_q;
        bwd_mem[free_q[IB-1:0]] <= {1'b0, idx_q};
      end
      all_pkg::CMD_INS_FIX: begin
        // link neighbor: before -> prev.fwd, after -> next.bwd, append -> old tail.fwd
        if (op_q == all_pkg::OP_INS_BEFORE) begin
          if (nbr_q != NONE) fwd_mem[nbr_q[IB-1:0]] <= new_q;
        end else if (op_q == all_pkg::OP_INS_AFTER) begin
          if (nbr_q != NONE) bwd_mem[nbr_q[IB-1:0]] <= new_q;
        end else if (nbr_q != NONE) begin
          fwd_mem[nbr_q[IB-1:0]] <= new_q;
        end
      end
      all_pkg::CMD_DEL: begin
        if (rd_bwd_q != NONE) fwd_mem[rd_bwd_q[IB-1:0]] <= rd_fwd_q;
      end
      all_pkg::CMD_DEL_FIX: begin
        if (rd_fwd_q != NONE) bwd_mem[rd_fwd_q[IB-1:0]] <= rd_bwd_q;
      end
      all_pkg::CMD_RESULT: begin
        if (op_q == all_pkg::OP_DELETE && ctl_i.status == all_pkg::ST_OK)
          fwd_mem[cur_q[IB-1:0]] <= free_q;
        else if (op_q == all_pkg::OP_INS_BEFORE && ctl_i.status == all_pkg::ST_OK)
          bwd_mem[idx_q] <= new_q;
        else if (op_q == all_pkg::OP_INS_AFTER && ctl_i.status == all_pkg::ST_OK)
          fwd_mem[idx_q] <= new_q;
      end
      default: ;
    endcase
  end

  // Payload capture and result staging.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == all_pkg::CMD_LATCH) begin
      op_q  <= op_i;
      val_q <= item_value_i;
      tag_q <= type_tag_i;
      idx_q <= slot_i;
    end
    if (ctl_i.cmd == all_pkg::CMD_APPEND || ctl_i.cmd == all_pkg::CMD_INS_B ||
        ctl_i.cmd == all_pkg::CMD_INS_A) begin
      new_q <= free_q;
      // hold the neighbor to patch: old prev, old next or old tail
      if (ctl_i.cmd == all_pkg::CMD_INS_B)      nbr_q <= rd_bwd_q;
      else if (ctl_i.cmd == all_pkg::CMD_INS_A) nbr_q <= rd_fwd_q;
      else                                      nbr_q <= tail_q;
    end
    if (ctl_i.cmd == all_pkg::CMD_RESULT) begin
      st_q <= ctl_i.status;
      if (ctl_i.use_node) begin
        rs_q <= (op_q == all_pkg::OP_APPEND || op_q == all_pkg::OP_INS_BEFORE ||
                 op_q == all_pkg::OP_INS_AFTER) ? new_q : cur_q;
        rv_q <= rd_val_q;
        rt_q <= rd_tag_q;
        rn_q <= rd_fwd_q;
        rp_q <= rd_bwd_q;
      end else begin
        rs_q <= NONE;
        rv_q <= '0;
        rt_q <= '0;
        rn_q <= NONE;
        rp_q <= NONE;
      end
    end
  end

  // List registers and cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= '0;
      in_use_q  <= '0;
      head_q    <= NONE;
      tail_q    <= NONE;
      free_q    <= '0;
      cnt_q     <= '0;
      cur_q     <= NONE;
      done_q    <= 1'b0;
    end else begin
      done_q <= (ctl_i.cmd == all_pkg::CMD_RESULT);
      case (ctl_i.cmd)
        all_pkg::CMD_LATCH:  cur_q <= (op_i == all_pkg::OP_READ) ? {1'b0, slot_i} : head_q;
        all_pkg::CMD_STEP:   cur_q <= rd_fwd_q;
        all_pkg::CMD_APPEND, all_pkg::CMD_INS_B, all_pkg::CMD_INS_A: begin
          fwd_vld_q[free_q[IB-1:0]] <= 1'b1;
          in_use_q[free_q[IB-1:0]]  <= 1'b1;
          free_q <= free_nxt_q;
          cnt_q  <= cnt_q + 1'b1;
          cur_q  <= free_q;
          if (ctl_i.cmd == all_pkg::CMD_APPEND) begin
            if (tail_q == NONE) head_q <= free_q;
            tail_q <= free_q;
          end else if (ctl_i.cmd == all_pkg::CMD_INS_B) begin
            if (rd_bwd_q == NONE) head_q <= free_q;
          end else begin
            if (rd_fwd_q == NONE) tail_q <= free_q;
          end
        end
        all_pkg::CMD_DEL: begin
          if (rd_bwd_q == NONE) head_q <= rd_fwd_q;
          if (rd_fwd_q == NONE) tail_q <= rd_bwd_q;
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          in_use_q[cur_q[IB-1:0]] <= 1'b0;
        end
        all_pkg::CMD_RESULT: begin
          if (op_q == all_pkg::OP_DELETE && ctl_i.status == all_pkg::ST_OK) begin
            free_q <= cur_q;
            fwd_vld_q[cur_q[IB-1:0]] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = st_q;
  assign result_slot_o  = rs_q;
  assign result_value_o = rv_q;
  assign result_tag_o   = rt_q;
  assign next_slot_o    = rn_q;
  assign prev_slot_o    = rp_q;
  assign count_o        = cnt_q;
  assign head_slot_o    = head_q;
  assign tail_slot_o    = tail_q;
endmodule

>>> rtl/all_ctrl.sv
// Controller state machine sequencing one operation of the list engine.
module all_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              done_i,
  output logic              busy_o,
  input  all_pkg::all_sts_t sts_i,
  output all_pkg::all_ctl_t ctl_o
);
  all_pkg::ctrl_state_e state_q, state_d;
  all_pkg::status_e err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= all_pkg::S_IDLE;
      err_q   <= all_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    err_d        = err_q;
    ctl_o.cmd    = all_pkg::CMD_NONE;
    ctl_o.status = all_pkg::ST_OK;
    ctl_o.use_node = 1'b0;
    busy_o       = (state_q != all_pkg::S_IDLE);
    case (state_q)
      all_pkg::S_IDLE: begin
        if (start_i) begin
          ctl_o.cmd = all_pkg::CMD_LATCH;
          state_d   = all_pkg::S_DISPATCH;
        end
      end
      all_pkg::S_DISPATCH: begin
        case (sts_i.op)
          all_pkg::OP_APPEND: begin
            if (sts_i.free_ok) begin
              ctl_o.cmd = all_pkg::CMD_RD_FREE;
              state_d   = all_pkg::S_LINK;
            end else begin
              err_d = all_pkg::ST_FULL; state_d = all_pkg::S_ERR;
            end
          end
          all_pkg::OP_INS_BEFORE, all_pkg::OP_INS_AFTER: begin
            if (!sts_i.idx_ok) begin
              err_d = all_pkg::ST_BADSLOT; state_d = all_pkg::S_ERR;
            end else if (!sts_i.free_ok) begin
              err_d = all_pkg::ST_FULL; state_d = all_pkg::S_ERR;
            end else begin
              ctl_o.cmd = all_pkg::CMD_RD_FREE;
              state_d   = all_pkg::S_RDIDX;
            end
          end
          all_pkg::OP_DELETE, all_pkg::OP_FIND: state_d = all_pkg::S_WALK;
          all_pkg::OP_READ: begin
            if (sts_i.idx_ok) begin
              ctl_o.cmd = all_pkg::CMD_RD_IDX; state_d = all_pkg::S_OK;
            end else begin
              err_d = all_pkg::ST_BADSLOT; state_d = all_pkg::S_ERR;
            end
          end
          default: begin
            err_d = all_pkg::ST_OK; state_d = all_pkg::S_ERR;
          end
        endcase
      end
      all_pkg::S_RDIDX: begin
        ctl_o.cmd = all_pkg::CMD_RD_IDX; state_d = all_pkg::S_LINK;
      end
      all_pkg::S_LINK: begin
        case (sts_i.op)
          all_pkg::OP_APPEND:     ctl_o.cmd = all_pkg::CMD_APPEND;
          all_pkg::OP_INS_BEFORE: ctl_o.cmd = all_pkg::CMD_INS_B;
          default:                ctl_o.cmd = all_pkg::CMD_INS_A;
        endcase
        state_d = all_pkg::S_FIX;
      end
      all_pkg::S_FIX: begin
        ctl_o.cmd = all_pkg::CMD_INS_FIX; state_d = all_pkg::S_REREAD;
      end
      all_pkg::S_REREAD: begin
        ctl_o.cmd = all_pkg::CMD_RD_CUR; state_d = all_pkg::S_OK;
      end
      // Walk from head: read, then compare.
      all_pkg::S_WALK: begin
        if (sts_i.cur_none) begin
          err_d = all_pkg::ST_NOTFOUND; state_d = all_pkg::S_ERR;
        end else begin
          ctl_o.cmd = all_pkg::CMD_RD_CUR; state_d = all_pkg::S_CHECK;
        end
      end
      all_pkg::S_CHECK: begin
        if (sts_i.match) begin
          state_d = (sts_i.op == all_pkg::OP_DELETE) ? all_pkg::S_DEL : all_pkg::S_OK;
        end else begin
          ctl_o.cmd = all_pkg::CMD_STEP; state_d = all_pkg::S_WALK;
        end
      end
      all_pkg::S_DEL: begin
        ctl_o.cmd = all_pkg::CMD_DEL; state_d = all_pkg::S_DELFIX;
      end
      all_pkg::S_DELFIX: begin
        ctl_o.cmd = all_pkg::CMD_DEL_FIX; state_d = all_pkg::S_OK;
      end
      all_pkg::S_OK: begin
        ctl_o.cmd = all_pkg::CMD_RESULT; ctl_o.use_node = 1'b1;
        state_d = all_pkg::S_WAIT;
      end
      all_pkg::S_ERR: begin
        ctl_o.cmd = all_pkg::CMD_RESULT; ctl_o.status = err_q;
        state_d = all_pkg::S_WAIT;
      end
      all_pkg::S_WAIT: begin
        if (done_i) state_d = all_pkg::S_IDLE;
      end
      default: state_d = all_pkg::S_IDLE;
    endcase
  end
endmodule

>>> rtl/array_linked_list_engine.sv
// Top level of the array linked list engine.
// One operation at a time: raise start while busy is low and the command is
// taken at that clock edge; the result appears for exactly one cycle with
// result_valid_o high and cannot be stalled. Find and delete walk the list
// from the head, and the single node-memory read port makes every list step
// a read state followed by a compare state. count, head and tail always
// show the list as it stands after the operation.
module array_linked_list_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    op_i,
  input  logic [all_pkg::ValueBits-1:0] item_value_i,
  input  logic [all_pkg::TagBits-1:0]   type_tag_i,
  input  logic [all_pkg::IdxBits-1:0]   slot_i,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic [all_pkg::SlotBits-1:0]  result_slot_o,
  output logic [all_pkg::ValueBits-1:0] result_value_o,
  output logic [all_pkg::TagBits-1:0]   result_tag_o,
  output logic [all_pkg::SlotBits-1:0]  next_slot_o,
  output logic [all_pkg::SlotBits-1:0]  prev_slot_o,
  output logic [all_pkg::SlotBits-1:0]  count_o,
  output logic [all_pkg::SlotBits-1:0]  head_slot_o,
  output logic [all_pkg::SlotBits-1:0]  tail_slot_o
);
  all_pkg::all_ctl_t ctl;
  all_pkg::all_sts_t sts;
  logic done;

  all_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .done_i(done), .busy_o(busy),
    .sts_i(sts), .ctl_o(ctl)
  );

  all_datapath u_dp (
    .clk_i, .rst_ni, .op_i, .item_value_i, .type_tag_i, .slot_i,
    .ctl_i(ctl), .sts_o(sts), .done_o(done),
    .status_o, .result_slot_o, .result_value_o, .result_tag_o,
    .next_slot_o, .prev_slot_o, .count_o, .head_slot_o, .tail_slot_o
  );

  assign result_valid_o = done;
endmodule

>>> test/list_checker.sv
// Checker for the array linked list engine: predicts each result and compares it.
module list_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    op_i,
  input  logic [all_pkg::ValueBits-1:0] item_value_i,
  input  logic [all_pkg::TagBits-1:0]   type_tag_i,
  input  logic [all_pkg::IdxBits-1:0]   slot_i,
  input  logic                          result_valid_o,
  input  logic [1:0]                    status_o,
  input  logic [all_pkg::SlotBits-1:0]  result_slot_o,
  input  logic [all_pkg::ValueBits-1:0] result_value_o,
  input  logic [all_pkg::TagBits-1:0]   result_tag_o,
  input  logic [all_pkg::SlotBits-1:0]  next_slot_o,
  input  logic [all_pkg::SlotBits-1:0]  prev_slot_o,
  input  logic [all_pkg::SlotBits-1:0]  count_o,
  input  logic [all_pkg::SlotBits-1:0]  head_slot_o,
  input  logic [all_pkg::SlotBits-1:0]  tail_slot_o,
  output int                            fail_count,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import all_pkg::*;

  typedef logic [SlotBits-1:0] slot_t;

  typedef struct packed {
    status_e               status;
    slot_t                 node;
    logic [ValueBits-1:0]  value;
    logic [TagBits-1:0]    tag;
    slot_t                 next;
    slot_t                 prev;
    slot_t                 count;
    slot_t                 head;
    slot_t                 tail;
  } list_result_t;

  // Shadow copy of the node pool
  logic [ValueBits-1:0] pool_value [MaxNodes];
  logic [TagBits-1:0]   pool_tag   [MaxNodes];
  slot_t                pool_next  [MaxNodes];
  slot_t                pool_prev  [MaxNodes];
  logic                 pool_used  [MaxNodes];
  slot_t                list_head, list_tail, free_slot, list_count;

  list_result_t pending_results[$];

  assign outstanding = pending_results.size();

  function automatic list_result_t describe(status_e st, slot_t s);
    list_result_t r;
    r = '0;
    r.status = st;
    r.node   = NoneSlot;
    r.next   = NoneSlot;
    r.prev   = NoneSlot;
    if (s != NoneSlot) begin
      r.node  = s;
      r.value = pool_value[s];
      r.tag   = pool_tag[s];
      r.next  = pool_next[s];
      r.prev  = pool_prev[s];
    end
    r.count = list_count;
    r.head  = list_head;
    r.tail  = list_tail;
    return r;
  endfunction

  function automatic slot_t find_first(logic [ValueBits-1:0] v);
    slot_t cur;
    cur = list_head;
    for (int k = 0; k < MaxNodes; k++) begin
      if (cur == NoneSlot) return NoneSlot;
      if (pool_value[cur] == v) return cur;
      cur = pool_next[cur];
    end
    return NoneSlot;
  endfunction

  function automatic slot_t grab_node(logic [ValueBits-1:0] v, logic [TagBits-1:0] t);
    slot_t s;
    s = free_slot;
    free_slot = pool_next[s];
    pool_value[s] = v;
    pool_tag[s] = t;
    pool_used[s] = 1'b1;
    list_count++;
    return s;
  endfunction

  // Apply one command to the shadow list and return what the block must report
  function automatic list_result_t apply_command(logic [2:0] op, logic [ValueBits-1:0] v,
                                                 logic [TagBits-1:0] t, logic [IdxBits-1:0] idx);
    slot_t s, p, n;
    list_result_t r;
    case (op)
      OP_APPEND: begin
        if (free_slot == NoneSlot) return describe(ST_FULL, NoneSlot);
        s = grab_node(v, t);
        pool_next[s] = NoneSlot;
        pool_prev[s] = list_tail;
        if (list_tail != NoneSlot) pool_next[list_tail] = s;
        else list_head = s;
        list_tail = s;
        return describe(ST_OK, s);
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (!pool_used[idx]) return describe(ST_BADSLOT, NoneSlot);
        if (free_slot == NoneSlot) return describe(ST_FULL, NoneSlot);
        s = grab_node(v, t);
        if (op == OP_INS_BEFORE) begin
          p = pool_prev[idx];
          pool_next[s] = slot_t'(idx);
          pool_prev[s] = p;
          if (p != NoneSlot) pool_next[p] = s;
          else list_head = s;
          pool_prev[idx] = s;
        end else begin
          n = pool_next[idx];
          pool_next[s] = n;
          pool_prev[s] = slot_t'(idx);
          if (n != NoneSlot) pool_prev[n] = s;
          else list_tail = s;
          pool_next[idx] = s;
        end
        return describe(ST_OK, s);
      end
      OP_DELETE: begin
        s = find_first(v);
        if (s == NoneSlot) return describe(ST_NOTFOUND, NoneSlot);
        p = pool_prev[s];
        n = pool_next[s];
        if (p != NoneSlot) pool_next[p] = n;
        else list_head = n;
        if (n != NoneSlot) pool_prev[n] = p;
        else list_tail = p;
        if (list_count != 0) list_count--;
        pool_used[s] = 1'b0;
        // Report the removed node with its old links, then free it
        r = describe(ST_OK, s);
        pool_next[s] = free_slot;
        free_slot = s;
        return r;
      end
      OP_FIND: begin
        s = find_first(v);
        return describe(s == NoneSlot ? ST_NOTFOUND : ST_OK, s);
      end
      OP_READ: begin
        if (!pool_used[idx]) return describe(ST_BADSLOT, NoneSlot);
        return describe(ST_OK, slot_t'(idx));
      end
      default: return describe(ST_OK, NoneSlot);
    endcase
  endfunction

  // Watch both channels; a result is always older than the next accepted command
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < MaxNodes; i++) begin
        pool_next[i] = slot_t'(i + 1);
        pool_used[i] = 1'b0;
      end
      list_head = NoneSlot;
      list_tail = NoneSlot;
      free_slot = '0;
      list_count = '0;
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (result_valid_o) begin
        got = '{status_e'(status_o), result_slot_o, result_value_o, result_tag_o,
                next_slot_o, prev_slot_o, count_o, head_slot_o, tail_slot_o};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(apply_command(op_i, item_value_i, type_tag_i, slot_i));
    end
  end
endmodule

>>> test/tb_array_linked_list_engine.sv
// Testbench top for the array linked list engine: stimulus and verdict.
module tb_array_linked_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import all_pkg::*;

  logic                 clk_i, rst_ni, start, busy;
  logic [2:0]           op_i;
  logic [ValueBits-1:0] item_value_i;
  logic [TagBits-1:0]   type_tag_i;
  logic [IdxBits-1:0]   slot_i;
  logic                 result_valid_o;
  logic [1:0]           status_o;
  logic [SlotBits-1:0]  result_slot_o, next_slot_o, prev_slot_o;
  logic [SlotBits-1:0]  count_o, head_slot_o, tail_slot_o;
  logic [ValueBits-1:0] result_value_o;
  logic [TagBits-1:0]   result_tag_o;
  int                   fail_count, outstanding;
  bit                   gaps_on;

  array_linked_list_engine uut (.*);

  list_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Send one command beat; start stays high straight into the next beat unless a gap falls
  task automatic send_cmd(logic [2:0] op, logic [ValueBits-1:0] v, logic [TagBits-1:0] t,
                          logic [IdxBits-1:0] s);
    int gap;
    gap = (gaps_on && $urandom_range(99) < 38) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    // wait out the previous command so a gap really idles the input
    while (busy) @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    op_i = op;
    item_value_i = v;
    type_tag_i = t;
    slot_i = s;
    do @(posedge clk_i); while (busy);
  endtask

  // Mostly small values so finds and deletes hit, now and then any value
  function automatic logic [ValueBits-1:0] pick_value();
    return ($urandom_range(9) == 0) ? ValueBits'($urandom) : ValueBits'($urandom_range(15));
  endfunction

  initial begin
    int grow;
    logic [2:0] op;
    start = 1'b0;
    op_i = '0;
    item_value_i = '0;
    type_tag_i = '0;
    slot_i = '0;
    gaps_on = 1'b1;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty list: bad slots, misses and unknown ops
    send_cmd(OP_READ, '0, '0, 6'd0);
    send_cmd(OP_INS_BEFORE, 32'd5, 8'd1, 6'd63);
    send_cmd(OP_DELETE, 32'd5, '0, '0);
    send_cmd(OP_FIND, 32'd5, '0, '0);
    send_cmd(3'd6, '1, '1, '1);
    // Field extremes, inserts at both ends, duplicates
    send_cmd(OP_APPEND, '0, '0, '0);
    send_cmd(OP_APPEND, '1, '1, '1);
    send_cmd(OP_INS_BEFORE, 32'd7, 8'h5a, 6'd0);
    send_cmd(OP_INS_AFTER, 32'd7, 8'ha5, 6'd1);
    send_cmd(OP_INS_AFTER, 32'h8000_0001, 8'h80, 6'd3);
    send_cmd(OP_FIND, 32'd7, '0, '0);
    send_cmd(OP_READ, '0, '0, 6'd2);
    send_cmd(OP_READ, '0, '0, 6'd63);
    send_cmd(OP_DELETE, 32'd7, '0, '0);
    send_cmd(OP_DELETE, 32'd7, '0, '0);
    send_cmd(OP_DELETE, '1, '0, '0);
    send_cmd(OP_FIND, 32'd99, '0, '0);
    send_cmd(3'd7, '0, '0, '0);
    send_cmd(OP_INS_BEFORE, 32'd3, 8'd3, 6'd2);

    // Random phases alternately grow and shrink the list so full and empty both occur
    for (int i = 0; i < 930; i++) begin
      gaps_on = !(i >= 300 && i < 450);
      grow = ((i / 90) % 2 == 0) ? 75 : 20;
      if ($urandom_range(99) < grow) op = OP_APPEND + 3'($urandom_range(2));
      else begin
        case ($urandom_range(9))
          0, 1, 2, 3: op = OP_DELETE;
          4, 5:       op = OP_FIND;
          6, 7, 8:    op = OP_READ;
          default:    op = 3'($urandom_range(7));
        endcase
      end
      send_cmd(op, pick_value(), 8'($urandom), 6'($urandom));
    end

    @(negedge clk_i);
    start = 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
